// ===== rtl/mes_pkg.sv =====
package mes_pkg;

    // Number format
    localparam int FRAC_BITS    = 24;
    localparam int NUMBER_WIDTH = 32;
    localparam int IN_W         = 32;

    // Shared multiplier: operands are one bit wider than a number so that
    // the split halves of the cardioid product fit as well.
    localparam int MW = NUMBER_WIDTH + 1;
    localparam int PW = 2 * MW;

    // Cardioid product: exact sum of the two partial products, then the
    // low ACC_W bits are the signed 64-bit value.
    localparam int ACC_W  = 64;
    localparam int SPLIT  = 16;
    localparam int AW     = (PW + SPLIT + 1 > ACC_W) ? PW + SPLIT + 1 : ACC_W;
    localparam int LW     = ACC_W - FRAC_BITS;
    localparam int TW     = NUMBER_WIDTH + 2;
    localparam int THW    = TW - SPLIT;

    // Escape compare width, wide enough to hold the limit constant
    localparam int CW = ((FRAC_BITS + 4 > NUMBER_WIDTH) ? FRAC_BITS + 4 : NUMBER_WIDTH) + 1;

    localparam int ESCAPE_RADIUS_SQ = 4;
    localparam logic signed [CW-1:0] LIMIT = CW'(ESCAPE_RADIUS_SQ) << FRAC_BITS;
    localparam logic signed [NUMBER_WIDTH:0] QUARTER =
        (NUMBER_WIDTH + 1)'(1) << (FRAC_BITS - 2);

    // Shade and iteration counts
    localparam int SHADE_W = 16;
    localparam int MAXIT_W = 16;
    localparam int SPAN_W  = MAXIT_W + 1;
    localparam int DVD_W   = 2 * SHADE_W;
    localparam int DIV_STEPS = SHADE_W;
    localparam int CNT_W   = $clog2(DIV_STEPS + 1);
    localparam logic [SHADE_W-1:0] SHADE_FULL  = 16'hFFFF;
    localparam logic [SPAN_W-1:0]  FIRST_SPAN  = SPAN_W'(8);
    localparam logic [MAXIT_W-1:0] MAXIT_RESET = MAXIT_W'(256);

    // Register map
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-3:0] REG_MAX_ITER = '0;

    typedef logic signed [NUMBER_WIDTH-1:0] t_num;
    typedef logic signed [MW-1:0]           t_mop;
    typedef logic signed [PW-1:0]           t_prod;

    typedef struct packed {
        logic               done;
        logic [SHADE_W-1:0] quot;
    } t_div_stat;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CARD_A,
        ST_CARD_B,
        ST_CARD_C,
        ST_CARD_D,
        ST_CARD_E,
        ST_CARD_F,
        ST_CARD_G,
        ST_CARD_H,
        ST_SPAN,
        ST_IT_SUM,
        ST_IT_MSUM,
        ST_IT_ZI,
        ST_IT_ZRSQ,
        ST_IT_ZISQ,
        ST_DIV,
        ST_FINISH
    } t_state;

    // Fixed-point square from a raw product: shift right by the fraction
    // bits, wrap to the number width.
    function automatic t_num sq_take(input t_prod p);
        logic signed [PW+FRAC_BITS+NUMBER_WIDTH-1:0] e;
        e = {{(FRAC_BITS + NUMBER_WIDTH){p[PW-1]}}, p};
        return e[FRAC_BITS +: NUMBER_WIDTH];
    endfunction

    function automatic t_mop to_mop(input t_num x);
        return {x[NUMBER_WIDTH-1], x};
    endfunction

endpackage

// ===== rtl/mes_mul.sv =====
module mes_mul import mes_pkg::*; (
    input  logic  i_clk,
    input  t_mop  i_a,
    input  t_mop  i_b,
    output t_prod o_prod
);

    t_prod r_prod;

    // full signed product, registered
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/mes_div.sv =====
module mes_div import mes_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DVD_W-1:0]   i_dividend,
    input  logic [SHADE_W-1:0] i_divisor,
    output t_div_stat          o_stat
);

    // Restoring divider, one quotient bit per cycle. The upper half of the
    // dividend must be below the divisor, so the quotient fits SHADE_W bits.

    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_done, n_done;
    logic [SHADE_W-1:0] r_rem, n_rem;
    logic [SHADE_W-1:0] r_q, n_q;
    logic [SHADE_W-1:0] r_dvs, n_dvs;
    logic [SHADE_W:0]   trial;
    logic [SHADE_W:0]   diff;

    always_comb begin
        trial  = {r_rem, r_q[SHADE_W-1]};
        diff   = trial - {1'b0, r_dvs};
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_rem  = r_rem;
        n_q    = r_q;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_rem = i_dividend[DVD_W-1:SHADE_W];
            n_q   = i_dividend[SHADE_W-1:0];
            n_dvs = i_divisor;
            n_cnt = CNT_W'(DIV_STEPS);
        end else if (r_cnt != '0) begin
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = diff[SHADE_W-1:0];
                n_q   = {r_q[SHADE_W-2:0], 1'b1};
            end else begin
                n_rem = trial[SHADE_W-1:0];
                n_q   = {r_q[SHADE_W-2:0], 1'b0};
            end
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_q   <= n_q;
        r_dvs <= n_dvs;
    end

    assign o_stat.done = r_done;
    assign o_stat.quot = r_q;

endmodule

// ===== rtl/mandelbrot_escape_shade.sv =====
// Channel   Direction  Handshake                 Word
// --------  ---------  ------------------------  ----------------------------------
// in        input      i_in_valid / o_in_stall   i_c_real, i_c_imag (signed, fixed)
// out       output     o_out_valid / i_out_stall o_shade (unsigned 16 bits)
// config    input      APB psel/penable/pwrite   max_iterations at byte address 0
//
// One point at a time. A point in the main cardioid finishes after the
// cardioid test; any other point runs n iterations over k checkpoint spans,
// and when it escapes, the bit-serial divider scales the escape count. Each
// iteration squares three times on the single shared 33x33 multiplier.
// Reset (synchronous, active low) clears the sequencer and the output valid and
// sets max_iterations to 256. o_in_stall is high while a point is in work; a
// stalled output word holds, and the next point is taken meanwhile.
module mandelbrot_escape_shade import mes_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input words
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [IN_W-1:0]  i_c_real,
    input  logic signed [IN_W-1:0]  i_c_imag,
    // output words
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [SHADE_W-1:0]      o_shade,
    // configuration
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready
);

    // ---------------------------------------------------------------
    // Sequencer and control registers
    // ---------------------------------------------------------------
    t_state               r_state, n_state;
    logic                 r_ovalid, n_ovalid;
    logic [MAXIT_W-1:0]   r_max_iter, n_max_iter;

    // ---------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------
    t_num                      r_cr, n_cr;       // point
    t_num                      r_ci, n_ci;
    t_num                      r_zr, n_zr;       // orbit
    t_num                      r_zi, n_zi;
    t_num                      r_zrsq, n_zrsq;   // squares of the orbit
    t_num                      r_zisq, n_zisq;   // also holds sq(ci) for the cardioid test
    t_num                      r_ckr, n_ckr;     // checkpoint
    t_num                      r_cki, n_cki;
    t_num                      r_s, n_s;         // zr + zi
    t_num                      r_zrn, n_zrn;     // next zr
    t_num                      r_d, n_d;         // ci - zrsq - zisq
    t_num                      r_am, n_am;       // cr - 1/4, wrapped
    t_num                      r_sqa, n_sqa;
    t_num                      r_q, n_q;
    logic signed [NUMBER_WIDTH:0] r_t1, n_t1;    // cr - 1/4, exact
    logic signed [TW-1:0]      r_t, n_t;         // q + (cr - 1/4), exact
    t_prod                     r_plo, n_plo;     // q * low half of t
    logic signed [AW-1:0]      r_acc, n_acc;     // q * t, exact
    logic [MAXIT_W-1:0]        r_p, n_p;         // iteration index
    logic [SPAN_W-1:0]         r_span, n_span;   // end of current span
    logic [SHADE_W-1:0]        r_pend, n_pend;   // finished shade
    logic [SHADE_W-1:0]        r_oshade, n_oshade;

    // ---------------------------------------------------------------
    // Shared units
    // ---------------------------------------------------------------
    t_mop       mul_a, mul_b;
    t_prod      prod;
    logic       div_start;
    logic [DVD_W-1:0] div_dvd;
    t_div_stat  div_stat;

    mes_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    mes_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (r_max_iter),
        .o_stat     (div_stat)
    );

    // ---------------------------------------------------------------
    // Combinational helpers
    // ---------------------------------------------------------------
    t_num                      sq_now;      // square out of the multiplier
    logic signed [NUMBER_WIDTH:0] in_t1;
    logic signed [NUMBER_WIDTH:0] card_adj;
    logic signed [NUMBER_WIDTH:0] card_rhs;  // sq(ci)/4, toward zero
    logic signed [LW-1:0]      card_rhs_x;
    logic signed [LW-1:0]      card_lhs;
    logic signed [AW-1:0]      acc_hi;
    logic signed [AW-1:0]      acc_lo;
    t_num                      esc_sum;
    logic signed [CW-1:0]      esc_x;
    logic                      escape;
    logic                      cycled;
    logic [SPAN_W-1:0]         span_dbl;
    logic [SPAN_W-1:0]         span_cap;
    logic [SPAN_W-1:0]         maxit_x;
    logic [SPAN_W-1:0]         p_inc;
    logic                      in_acc;
    logic                      out_free;
    logic                      cfg_hit;
    logic                      cfg_wr;

    assign sq_now  = sq_take(prod);
    assign in_t1   = {i_c_real[NUMBER_WIDTH-1], i_c_real[NUMBER_WIDTH-1:0]} - QUARTER;

    assign card_adj   = {r_zisq[NUMBER_WIDTH-1], r_zisq}
                      + {{(NUMBER_WIDTH-1){1'b0}}, r_zisq[NUMBER_WIDTH-1], r_zisq[NUMBER_WIDTH-1]};
    assign card_rhs   = card_adj >>> 2;
    assign card_rhs_x = {{(LW-NUMBER_WIDTH-1){card_rhs[NUMBER_WIDTH]}}, card_rhs};
    assign card_lhs   = r_acc[ACC_W-1:FRAC_BITS];

    assign acc_hi = {{(AW-PW){prod[PW-1]}}, prod} <<< SPLIT;
    assign acc_lo = {{(AW-PW){r_plo[PW-1]}}, r_plo};

    assign esc_sum = r_zrsq + sq_now;
    assign esc_x   = {{(CW-NUMBER_WIDTH){esc_sum[NUMBER_WIDTH-1]}}, esc_sum};
    assign escape  = (esc_x > LIMIT);
    assign cycled  = (r_zr == r_ckr) && (r_zi == r_cki);

    assign maxit_x  = {1'b0, r_max_iter};
    assign span_dbl = {r_span[SPAN_W-2:0], 1'b0};
    assign span_cap = (span_dbl > maxit_x) ? maxit_x : span_dbl;
    assign p_inc    = {1'b0, r_p} + SPAN_W'(1);

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_ovalid || !i_out_stall;
    assign cfg_hit  = (paddr[ADDR_W-1:2] == REG_MAX_ITER);
    assign cfg_wr   = psel && penable && pwrite && cfg_hit;

    assign div_dvd  = DVD_W'(r_p) * DVD_W'(SHADE_FULL);

    // ---------------------------------------------------------------
    // Next state, multiplier operands, datapath updates
    // ---------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_ovalid   = r_ovalid && i_out_stall;
        n_max_iter = cfg_wr ? pwdata[MAXIT_W-1:0] : r_max_iter;
        n_cr   = r_cr;   n_ci   = r_ci;
        n_zr   = r_zr;   n_zi   = r_zi;
        n_zrsq = r_zrsq; n_zisq = r_zisq;
        n_ckr  = r_ckr;  n_cki  = r_cki;
        n_s    = r_s;    n_zrn  = r_zrn;  n_d = r_d;
        n_am   = r_am;   n_sqa  = r_sqa;  n_q = r_q;
        n_t1   = r_t1;   n_t    = r_t;
        n_plo  = r_plo;  n_acc  = r_acc;
        n_p    = r_p;    n_span = r_span;
        n_pend = r_pend; n_oshade = r_oshade;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_cr   = i_c_real[NUMBER_WIDTH-1:0];
                    n_ci   = i_c_imag[NUMBER_WIDTH-1:0];
                    n_zr   = i_c_real[NUMBER_WIDTH-1:0];
                    n_zi   = i_c_imag[NUMBER_WIDTH-1:0];
                    n_t1   = in_t1;
                    n_am   = in_t1[NUMBER_WIDTH-1:0];
                    n_p    = '0;
                    n_span = FIRST_SPAN;
                    n_state = ST_CARD_A;
                end
            end
            // cardioid test
            ST_CARD_A: begin
                mul_a = to_mop(r_am);
                mul_b = to_mop(r_am);
                n_state = ST_CARD_B;
            end
            ST_CARD_B: begin
                n_sqa = sq_now;
                mul_a = to_mop(r_ci);
                mul_b = to_mop(r_ci);
                n_state = ST_CARD_C;
            end
            ST_CARD_C: begin
                n_zisq = sq_now;
                n_q    = r_sqa + sq_now;
                mul_a  = to_mop(r_cr);
                mul_b  = to_mop(r_cr);
                n_state = ST_CARD_D;
            end
            ST_CARD_D: begin
                n_zrsq = sq_now;
                n_t    = {{2{r_q[NUMBER_WIDTH-1]}}, r_q} + {r_t1[NUMBER_WIDTH], r_t1};
                n_state = ST_CARD_E;
            end
            ST_CARD_E: begin
                mul_a = to_mop(r_q);
                mul_b = {{(MW-SPLIT){1'b0}}, r_t[SPLIT-1:0]};
                n_state = ST_CARD_F;
            end
            ST_CARD_F: begin
                n_plo = prod;
                mul_a = to_mop(r_q);
                mul_b = {{(MW-THW){r_t[TW-1]}}, r_t[TW-1:SPLIT]};
                n_state = ST_CARD_G;
            end
            ST_CARD_G: begin
                n_acc = acc_hi + acc_lo;
                n_state = ST_CARD_H;
            end
            ST_CARD_H: begin
                if (card_lhs < card_rhs_x) begin
                    n_pend  = '0;
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_SPAN;
                end
            end
            // new checkpoint, span doubles up to the limit
            ST_SPAN: begin
                n_ckr  = r_zr;
                n_cki  = r_zi;
                n_span = span_cap;
                if ({1'b0, r_p} < span_cap) begin
                    n_state = ST_IT_SUM;
                end else if (span_cap == maxit_x) begin
                    n_pend  = '0;
                    n_state = ST_FINISH;
                end
            end
            // one iteration of z = z*z + c
            ST_IT_SUM: begin
                n_s   = r_zr + r_zi;
                n_zrn = r_zrsq - r_zisq + r_cr;
                n_d   = r_ci - r_zrsq - r_zisq;
                n_state = ST_IT_MSUM;
            end
            ST_IT_MSUM: begin
                mul_a = to_mop(r_s);
                mul_b = to_mop(r_s);
                n_state = ST_IT_ZI;
            end
            ST_IT_ZI: begin
                n_zi  = sq_now + r_d;
                n_zr  = r_zrn;
                mul_a = to_mop(r_zrn);
                mul_b = to_mop(r_zrn);
                n_state = ST_IT_ZRSQ;
            end
            ST_IT_ZRSQ: begin
                n_zrsq = sq_now;
                mul_a  = to_mop(r_zi);
                mul_b  = to_mop(r_zi);
                n_state = ST_IT_ZISQ;
            end
            ST_IT_ZISQ: begin
                n_zisq = sq_now;
                if (escape) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end else if (cycled) begin
                    n_pend  = '0;
                    n_state = ST_FINISH;
                end else begin
                    n_p = p_inc[MAXIT_W-1:0];
                    if (p_inc == r_span) begin
                        if (r_span == maxit_x) begin
                            n_pend  = '0;
                            n_state = ST_FINISH;
                        end else begin
                            n_state = ST_SPAN;
                        end
                    end else begin
                        n_state = ST_IT_SUM;
                    end
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    n_pend  = div_stat.quot;
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_oshade = r_pend;
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_ovalid   <= 1'b0;
            r_max_iter <= MAXIT_RESET;
        end else begin
            r_state    <= n_state;
            r_ovalid   <= n_ovalid;
            r_max_iter <= n_max_iter;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cr   <= n_cr;   r_ci   <= n_ci;
        r_zr   <= n_zr;   r_zi   <= n_zi;
        r_zrsq <= n_zrsq; r_zisq <= n_zisq;
        r_ckr  <= n_ckr;  r_cki  <= n_cki;
        r_s    <= n_s;    r_zrn  <= n_zrn;  r_d <= n_d;
        r_am   <= n_am;   r_sqa  <= n_sqa;  r_q <= n_q;
        r_t1   <= n_t1;   r_t    <= n_t;
        r_plo  <= n_plo;  r_acc  <= n_acc;
        r_p    <= n_p;    r_span <= n_span;
        r_pend <= n_pend; r_oshade <= n_oshade;
    end

    // ---------------------------------------------------------------
    // Ports
    // ---------------------------------------------------------------
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_shade     = r_oshade;
    assign pready      = 1'b1;
    assign prdata      = cfg_hit ? {{(DATA_W-MAXIT_W){1'b0}}, r_max_iter} : '0;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_CARD_A))
        else $error("accepted word did not start the cardioid test");

    a_iter_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IT_SUM) |-> ({1'b0, r_p} < r_span))
        else $error("iteration index outside its span");

    a_span_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IT_SUM) |-> (r_span <= maxit_x))
        else $error("span exceeds max_iterations");

    a_shade_below_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DIV) && div_stat.done) |-> (div_stat.quot != SHADE_FULL))
        else $error("escape shade reached full scale");

    a_div_only_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> (r_state == ST_DIV) && !div_stat.done)
        else $error("divider started outside the escape path");

endmodule
